[rtl/seti_pkg.sv]
// ----------------------------------------------------------------------------
// seti_pkg
// shared types, constants and easing tables for the spring easing evaluator
// ----------------------------------------------------------------------------
package seti_pkg;

	localparam int TABLE_POINTS  = 33;
	localparam int SEGMENTS      = TABLE_POINTS - 1;
	localparam int STORED_POINTS = 33;
	localparam int FULL_Q10      = 1023;

	typedef enum logic [1:0] {
		CLS_START  = 2'd0,
		CLS_END    = 2'd1,
		CLS_INTERP = 2'd2
	} cls_t;

	// classified item handed from front to back
	typedef struct packed {
		cls_t               cls;
		logic [22:0]        scaled;   // t * segments, t < 65536
		logic [15:0]        dur;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic               sel;
	} item_t;

	function automatic logic [10:0] curve_at(input logic sel, input logic [5:0] i);
		logic [5:0] k;
		logic [10:0] v;
		k = (i > 6'd32) ? 6'd32 : i;
		v = 11'd0;
		if (!sel) begin
			case (k)
				6'd0: v = 11'd0;    6'd1: v = 11'd36;   6'd2: v = 11'd127;  6'd3: v = 11'd248;
				6'd4: v = 11'd383;  6'd5: v = 11'd517;  6'd6: v = 11'd641;  6'd7: v = 11'd751;
				6'd8: v = 11'd844;  6'd9: v = 11'd919;  6'd10: v = 11'd977; 6'd11: v = 11'd1020;
				6'd12: v = 11'd1049; 6'd13: v = 11'd1066; 6'd14: v = 11'd1076; 6'd15: v = 11'd1079;
				6'd16: v = 11'd1077; 6'd17: v = 11'd1072; 6'd18: v = 11'd1065; 6'd19: v = 11'd1058;
				6'd20: v = 11'd1051; 6'd21: v = 11'd1044; 6'd22: v = 11'd1038; 6'd23: v = 11'd1033;
				6'd24: v = 11'd1029; 6'd25: v = 11'd1026; 6'd26: v = 11'd1023; 6'd27: v = 11'd1022;
				6'd28: v = 11'd1021; 6'd29: v = 11'd1020; 6'd30: v = 11'd1020; 6'd31: v = 11'd1020;
				default: v = 11'd1023;
			endcase
		end else begin
			case (k)
				6'd0: v = 11'd0;    6'd1: v = 11'd20;   6'd2: v = 11'd70;   6'd3: v = 11'd139;
				6'd4: v = 11'd218;  6'd5: v = 11'd302;  6'd6: v = 11'd385;  6'd7: v = 11'd464;
				6'd8: v = 11'd539;  6'd9: v = 11'd607;  6'd10: v = 11'd669; 6'd11: v = 11'd724;
				6'd12: v = 11'd772; 6'd13: v = 11'd814; 6'd14: v = 11'd850; 6'd15: v = 11'd881;
				6'd16: v = 11'd907; 6'd17: v = 11'd929; 6'd18: v = 11'd947; 6'd19: v = 11'd962;
				6'd20: v = 11'd975; 6'd21: v = 11'd985; 6'd22: v = 11'd994; 6'd23: v = 11'd1000;
				6'd24: v = 11'd1006; 6'd25: v = 11'd1010; 6'd26: v = 11'd1014; 6'd27: v = 11'd1016;
				6'd28: v = 11'd1018; 6'd29: v = 11'd1020; 6'd30: v = 11'd1021; 6'd31: v = 11'd1022;
				default: v = 11'd1023;
			endcase
		end
		return v;
	endfunction

endpackage

[rtl/seti_front.sv]
// ----------------------------------------------------------------------------
// seti_front
// classifies each time word and scales it by the segment count
// ----------------------------------------------------------------------------
module seti_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [16:0]   t,
	input  logic [15:0]          dur,
	input  logic signed [15:0]   lo,
	input  logic signed [15:0]   hi,
	input  logic                 sel,
	output logic                 out_vld,
	output seti_pkg::item_t      out_item
);
	import seti_pkg::*;

	item_t item_d;

	always_comb begin
		item_d        = '0;
		item_d.dur    = dur;
		item_d.lo     = lo;
		item_d.hi     = hi;
		item_d.sel    = sel;
		item_d.scaled = 23'(t[15:0]) * 23'(SEGMENTS);
		if (t >= $signed({1'b0, dur}))
			item_d.cls = CLS_END;
		else if (t <= 17'sd0)
			item_d.cls = CLS_START;
		else
			item_d.cls = CLS_INTERP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		out_item <= item_d;
	end

endmodule

[rtl/seti_divider.sv]
// ----------------------------------------------------------------------------
// seti_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module seti_divider #(
	parameter int NW = 23,
	parameter int DW = 16,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_vld,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [TW-1:0] out_tag
);
	logic          vld_q [NW+1];
	logic [NW-1:0] n_q [NW+1];
	logic [DW-1:0] r_q [NW+1];
	logic [DW-1:0] d_q [NW+1];
	logic [TW-1:0] t_q [NW+1];

	assign vld_q[0] = in_vld;
	assign n_q[0]   = num;
	assign r_q[0]   = '0;
	assign d_q[0]   = den;
	assign t_q[0]   = tag;

	for (genvar s = 0; s < NW; s++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		assign trial = {r_q[s], n_q[s][NW-1]};
		assign diff  = trial - {1'b0, d_q[s]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[s+1] <= 1'b0;
			else vld_q[s+1] <= vld_q[s];
		end
		always_ff @(posedge clk) begin
			d_q[s+1] <= d_q[s];
			t_q[s+1] <= t_q[s];
			if (!diff[DW]) begin
				r_q[s+1] <= diff[DW-1:0];
				n_q[s+1] <= {n_q[s][NW-2:0], 1'b1};
			end else begin
				r_q[s+1] <= trial[DW-1:0];
				n_q[s+1] <= {n_q[s][NW-2:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_q[NW];
	assign quo     = n_q[NW];
	assign rem     = r_q[NW];
	assign out_tag = t_q[NW];

endmodule

[rtl/seti_fifo.sv]
// ----------------------------------------------------------------------------
// seti_fifo
// short queue between front and back parts
// ----------------------------------------------------------------------------
module seti_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  seti_pkg::item_t wr_item,
	input  logic            rd_en,
	output logic            not_empty,
	output seti_pkg::item_t rd_item
);
	import seti_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t           mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign not_empty = cnt_q != '0;
	assign rd_item   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_item;
	end

endmodule

[rtl/seti_back.sv]
// ----------------------------------------------------------------------------
// seti_back
// segment division, table interpolation and span mapping
// ----------------------------------------------------------------------------
module seti_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  seti_pkg::item_t      in_item,
	output logic                 done,
	output logic signed [16:0]   level
);
	import seti_pkg::*;

	localparam int TW = $bits(item_t);

	// ceil(2^37 / 1023); exact floor division for dividends below 2^27
	localparam logic [27:0] RECIP_1023 = 28'd134348929;

	// stage a: segment index and remainder
	logic          dv_vld;
	logic [22:0]   dv_quo;
	logic [15:0]   dv_rem;
	item_t         dv_item;

	seti_divider #(.NW(23), .DW(16), .TW(TW)) u_div1 (
		.clk, .arst_n, .in_vld,
		.num(in_item.scaled), .den(in_item.dur), .tag(in_item),
		.out_vld(dv_vld), .quo(dv_quo), .rem(dv_rem), .out_tag(dv_item)
	);

	// stage b: table lookup, delta times remainder
	logic [5:0]          idx;
	logic                vb_vld_s1;
	item_t               item_s1;
	logic signed [11:0]  va_s1;
	logic signed [27:0]  prod_s1;

	always_comb begin
		if (dv_quo > 23'(SEGMENTS - 1)) idx = 6'(SEGMENTS - 1);
		else idx = dv_quo[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb_vld_s1 <= 1'b0;
		else vb_vld_s1 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		logic signed [11:0] a, b;
		a = $signed({1'b0, curve_at(dv_item.sel, idx)});
		b = $signed({1'b0, curve_at(dv_item.sel, idx + 6'd1)});
		item_s1 <= dv_item;
		va_s1   <= a;
		prod_s1 <= 28'(b - a) * $signed({12'd0, dv_rem});
	end

	// delta*rem / dur, truncated toward zero via magnitude division
	logic          d2_vld;
	logic [27:0]   d2_quo;
	logic [15:0]   d2_rem;
	logic [TW+12:0] d2_tag;

	seti_divider #(.NW(28), .DW(16), .TW(TW+13)) u_div2 (
		.clk, .arst_n, .in_vld(vb_vld_s1),
		.num(prod_s1[27] ? 28'(-prod_s1) : prod_s1), .den(item_s1.dur),
		.tag({item_s1, va_s1, prod_s1[27]}),
		.out_vld(d2_vld), .quo(d2_quo), .rem(d2_rem), .out_tag(d2_tag)
	);

	item_t              item_c;
	logic signed [11:0] va_c;
	logic               neg_c;
	assign {item_c, va_c, neg_c} = d2_tag;

	// stage c: progress times span
	logic               vc_vld_s2;
	item_t              item_s2;
	logic signed [27:0] m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_vld_s2 <= 1'b0;
		else vc_vld_s2 <= d2_vld;
	end

	always_ff @(posedge clk) begin
		logic signed [12:0] prog;
		logic signed [16:0] span;
		prog = 13'(va_c) + (neg_c ? -$signed({1'b0, d2_quo[11:0]})
			: $signed({1'b0, d2_quo[11:0]}));
		span = 17'(item_c.hi) - 17'(item_c.lo);
		item_s2 <= item_c;
		m_s2    <= 28'(span) * 28'(prog);
	end

	// stage d: magnitude of the scaled progress
	logic          vd_vld_s3;
	item_t         item_s3;
	logic          neg_s3;
	logic [26:0]   mag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_vld_s3 <= 1'b0;
		else vd_vld_s3 <= vc_vld_s2;
	end

	always_ff @(posedge clk) begin
		logic [27:0] m_abs;
		m_abs = m_s2[27] ? 28'(-m_s2) : m_s2;
		item_s3 <= item_s2;
		neg_s3  <= m_s2[27];
		mag_s3  <= m_abs[26:0];
	end

	// stage e: /1023 by reciprocal multiply
	logic          ve_vld_s4;
	item_t         item_s4;
	logic          neg_s4;
	logic [16:0]   quo_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ve_vld_s4 <= 1'b0;
		else ve_vld_s4 <= vd_vld_s3;
	end

	always_ff @(posedge clk) begin
		logic [54:0] p;
		p = 55'(mag_s3) * 55'(RECIP_1023);
		item_s4 <= item_s3;
		neg_s4  <= neg_s3;
		quo_s4  <= p[53:37];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ve_vld_s4;
	end

	always_ff @(posedge clk) begin
		logic [16:0] q;
		q = neg_s4 ? 17'(-quo_s4) : quo_s4;
		unique case (item_s4.cls)
			CLS_END:    level <= 17'(item_s4.hi);
			CLS_START:  level <= 17'(item_s4.lo);
			default:    level <= 17'(item_s4.lo) + $signed(q);
		endcase
	end

endmodule

[rtl/spring_easing_table_interp_top.sv]
// ----------------------------------------------------------------------------
// spring_easing_table_interp_top
// spring easing curve evaluator with table interpolation
// ----------------------------------------------------------------------------
// takes one time word per cycle (busy is never high) and returns its eased
// level on eased_level with done high for one cycle; the path runs through
// two bit-per-stage divider pipelines (segment index, interpolation) plus a
// short reciprocal multiply for the q10 scaling. the receiver cannot stall.
// configuration is sampled with each word, so write registers only while
// idle.
module spring_easing_table_interp_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [16:0]  elapsed_ticks,
	output logic                done,
	output logic signed [16:0]  eased_level,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import seti_pkg::*;

	localparam logic [1:0] REG_SEL = 2'd0, REG_RUN = 2'd1, REG_FROM = 2'd2, REG_TO = 2'd3;

	// config registers
	logic               curve_select_q;
	logic [15:0]        run_length_q;
	logic signed [15:0] from_level_q, to_level_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// byte address bits 1:0 are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_select_q <= 1'b0;
			run_length_q   <= '0;
			from_level_q   <= '0;
			to_level_q     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_SEL:  curve_select_q <= pwdata[0];
				REG_RUN:  run_length_q   <= pwdata[15:0];
				REG_FROM: from_level_q   <= pwdata[15:0];
				default:  to_level_q     <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SEL:  prdata = {31'd0, curve_select_q};
			REG_RUN:  prdata = {16'd0, run_length_q};
			REG_FROM: prdata = {{16{from_level_q[15]}}, from_level_q};
			default:  prdata = {{16{to_level_q[15]}}, to_level_q};
		endcase
	end

	// front: classify and scale
	logic  fr_vld;
	item_t fr_item;
	logic  q_ne;
	item_t q_item;

	seti_front u_front (
		.clk, .arst_n, .in_vld(start && !busy), .t(elapsed_ticks),
		.dur(run_length_q), .lo(from_level_q), .hi(to_level_q), .sel(curve_select_q),
		.out_vld(fr_vld), .out_item(fr_item)
	);

	// queue drains every cycle the back part sees an item
	seti_fifo #(.DEPTH(2)) u_fifo (
		.clk, .arst_n, .wr_en(fr_vld), .wr_item(fr_item),
		.rd_en(q_ne), .not_empty(q_ne), .rd_item(q_item)
	);

	seti_back u_back (
		.clk, .arst_n, .in_vld(q_ne), .in_item(q_item),
		.done, .level(eased_level)
	);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		fr_vld |=> q_ne) else $error("queue lost word");
	a_pready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule
